// ===== hw/rtl/tbik_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbik_pkg: shared types and constants for the two-bone IK joint solver
// Item and result layouts, the bundle carried along the pipeline, the latency
// of each unit and a signed multiply helper.
// ----------------------------------------------------------------------------
package tbik_pkg;

  // Register stages of each unit
  localparam int FRONT_LAT = 10;
  localparam int QDIV_BITS = 34;
  localparam int QDIV_LAT  = QDIV_BITS + 1;
  localparam int MID_LAT   = 4;
  localparam int ISQRT_LAT = 32;
  localparam int PROD_LAT  = 1;
  localparam int TDIV_BITS = 32;
  localparam int TDIV_LAT  = TDIV_BITS + 1;
  localparam int OUT_LAT   = 1;
  localparam int TOTAL_LAT = FRONT_LAT + QDIV_LAT + MID_LAT + ISQRT_LAT + PROD_LAT
                             + TDIV_LAT + OUT_LAT;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [30:0]        upper_length;
    logic [30:0]        lower_length;
    logic signed [31:0] bend_x;
    logic signed [31:0] bend_y;
    logic signed [31:0] bend_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] joint_x;
    logic signed [31:0] joint_y;
    logic signed [31:0] joint_z;
    logic               unreachable;
    logic               degenerate;
    logic               saturated;
  } out_t;

  // Per-item data that rides along the long units
  typedef struct packed {
    logic             zero;
    logic [2:0]       qneg;
    logic [61:0]      r1s;
    logic [2:0][29:0] cmn;
    logic [2:0]       cneg;
    logic             czero;
    logic [61:0]      l2;
    logic [2:0][31:0] q;
    logic             qsat;
    logic             unreach;
    logic [31:0]      h;
    logic [31:0]      len;
  } bundle_t;

  function automatic logic signed [63:0] smul32(logic signed [31:0] a,
                                                logic signed [31:0] b);
    logic signed [63:0] ax;
    logic signed [63:0] bx;
    ax = 64'(a);
    bx = 64'(b);
    return ax * bx;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/two_bone_ik_joint_solver_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_bone_ik_joint_solver_unit: two-bone IK middle-joint solver
// done rises for each taken item once it has passed every unit in the pipeline map.
// Throughput: one item per cycle; every unit is fully pipelined and busy
// stays low, so start may be held high indefinitely.
// Results cannot be stalled: each shows on result for one cycle with done.
// Reset (rst, synchronous) clears every valid bit; items in flight are dropped.
// ----------------------------------------------------------------------------
module two_bone_ik_joint_solver_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tbik_pkg::in_t  item,
  output logic           done,
  output tbik_pkg::out_t result
);

  // Pipeline map:
  //   front  (10)  squares, cross product, center numerator, normalized cross
  //   qdiv   (35)  circle center quotient, one bit per stage
  //   mid    (4)   round and clip center, |q|^2, radicand
  //   isqrt  (32)  circle radius h and cross length, side by side
  //   prod   (1)   h * normalized cross
  //   tdiv   (33)  sideways terms, rounded
  //   out    (1)   add to center, clip, flags

  logic accept;

  logic                                 fr_valid;
  logic [2:0][96:0]                     fr_num;
  logic [63:0]                          fr_den;
  tbik_pkg::bundle_t                    fr_tag;

  logic                                 qd_valid;
  logic [2:0][tbik_pkg::QDIV_BITS-1:0]  qd_quo;
  logic [2:0]                           qd_ovf;
  tbik_pkg::bundle_t                    qd_tag;

  logic                                 m1_valid, m2_valid, m3_valid, m4_valid;
  tbik_pkg::bundle_t                    m1_tag, m2_tag, m3_tag, m4_tag;
  tbik_pkg::bundle_t                    m1_tag_next, m4_tag_next;
  logic [2:0][63:0]                     qsq;
  logic [63:0]                          qq;
  logic [61:0]                          srad, srad_next;

  logic                                 sq_valid;
  logic [1:0][31:0]                     sq_root;
  tbik_pkg::bundle_t                    sq_tag;

  logic                                 pr_valid;
  tbik_pkg::bundle_t                    pr_tag, pr_tag_next;
  logic [2:0][61:0]                     prod;

  logic                                 td_valid;
  logic [2:0][tbik_pkg::TDIV_BITS-1:0]  td_term;
  tbik_pkg::bundle_t                    td_tag;

  tbik_pkg::out_t                       result_next;

  // Every stage advances every cycle, so the unit never pushes back
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  tbik_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .item      (item),
    .out_valid (fr_valid),
    .num       (fr_num),
    .den       (fr_den),
    .tag       (fr_tag)
  );

  tbik_qdiv u_qdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .num       (fr_num),
    .den       (fr_den),
    .in_tag    (fr_tag),
    .out_valid (qd_valid),
    .quo       (qd_quo),
    .ovf       (qd_ovf),
    .out_tag   (qd_tag)
  );

  // Valid bits of the stages kept here
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
      pr_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      m1_valid <= qd_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
      pr_valid <= sq_valid;
      done     <= td_valid;
    end
  end

  // Round the center quotient (half up), apply the sign, clip to 32 bits.
  // An overflowed quotient is forced to 2^33 so it always clips.
  always_comb begin
    logic [33:0] mg;
    m1_tag_next      = qd_tag;
    m1_tag_next.qsat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mg = qd_ovf[i] ? (34'(1) << 33) : 34'((35'(qd_quo[i]) + 35'd1) >> 1);
      if (!qd_tag.qneg[i]) begin
        if (mg > 34'(tbik_pkg::POS_MAX)) begin
          m1_tag_next.q[i] = tbik_pkg::POS_MAX;
          m1_tag_next.qsat = 1'b1;
        end else begin
          m1_tag_next.q[i] = mg[31:0];
        end
      end else begin
        if (mg > 34'(tbik_pkg::NEG_MIN)) begin
          m1_tag_next.q[i] = tbik_pkg::NEG_MIN;
          m1_tag_next.qsat = 1'b1;
        end else begin
          m1_tag_next.q[i] = 32'(-mg);
        end
      end
    end
  end

  // Radicand r1^2 - |q|^2; a clipped center always counts as unreachable
  always_comb begin
    m4_tag_next         = m3_tag;
    m4_tag_next.unreach = m3_tag.qsat || (qq > 64'(m3_tag.r1s));
    srad_next           = m4_tag_next.unreach ? 62'd0 : (m3_tag.r1s - qq[61:0]);
  end

  always_ff @(posedge clk) begin
    m1_tag <= m1_tag_next;
    m2_tag <= m1_tag;
    for (int i = 0; i < 3; i++) begin
      qsq[i] <= tbik_pkg::smul32(m1_tag.q[i], m1_tag.q[i]);
    end
    m3_tag <= m2_tag;
    qq     <= qsq[0] + qsq[1] + qsq[2];
    m4_tag <= m4_tag_next;
    srad   <= srad_next;
  end

  tbik_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m4_valid),
    .rad       ({64'(m4_tag.l2), 64'(srad)}),
    .in_tag    (m4_tag),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_tag   (sq_tag)
  );

  // Hold h and the length alongside the item
  always_comb begin
    pr_tag_next     = sq_tag;
    pr_tag_next.h   = sq_root[0];
    pr_tag_next.len = sq_root[1];
  end

  // h times each normalized cross component
  always_ff @(posedge clk) begin
    pr_tag <= pr_tag_next;
    for (int i = 0; i < 3; i++) begin
      prod[i] <= 62'(sq_root[0]) * 62'(sq_tag.cmn[i]);
    end
  end

  tbik_tdiv u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pr_valid),
    .prod      (prod),
    .den       (pr_tag.len),
    .in_tag    (pr_tag),
    .out_valid (td_valid),
    .quo       (td_term),
    .out_tag   (td_tag)
  );

  // Joint = center + sideways term, clipped; drop the term when the cross
  // product vanished, zero everything for a zero target.
  always_comb begin
    logic [2:0][31:0] jv;
    logic [33:0]      sq;
    logic [33:0]      st;
    logic [33:0]      sum;
    logic             sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sq  = {{2{td_tag.q[i][31]}}, td_tag.q[i]};
      st  = 34'(td_term[i]);
      sum = td_tag.cneg[i] ? (sq - st) : (sq + st);
      if (td_tag.czero) begin
        jv[i] = td_tag.q[i];
      end else if (!sum[33] && (sum[32] || sum[31])) begin
        jv[i] = tbik_pkg::POS_MAX;
        sat   = 1'b1;
      end else if (sum[33] && !(sum[32] && sum[31])) begin
        jv[i] = tbik_pkg::NEG_MIN;
        sat   = 1'b1;
      end else begin
        jv[i] = sum[31:0];
      end
    end
    if (td_tag.zero) begin
      result_next             = '0;
      result_next.degenerate  = 1'b1;
    end else begin
      result_next.joint_x     = jv[0];
      result_next.joint_y     = jv[1];
      result_next.joint_z     = jv[2];
      result_next.unreachable = td_tag.unreach;
      result_next.degenerate  = td_tag.czero;
      result_next.saturated   = sat | td_tag.qsat;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tbik_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbik_front: front end of the solver pipeline
// Squares, cross product, circle-center numerator and the normalized cross
// product with its squared length, over ten register stages.
// ----------------------------------------------------------------------------
module tbik_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  tbik_pkg::in_t     item,
  output logic              out_valid,
  output logic [2:0][96:0]  num,
  output logic [63:0]       den,
  output tbik_pkg::bundle_t tag
);

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] d;
    logic [30:0]      r1;
    logic [30:0]      r2;
    logic [2:0][31:0] pmag;
    logic [2:0]       pneg;
    logic [2:0][63:0] psq;
    logic [61:0]      r1s;
    logic [61:0]      r2s;
    logic [5:0][63:0] pd;
    logic [63:0]      pp;
    logic [2:0][64:0] c;
    logic [62:0]      dsig;
    logic [64:0]      t;
    logic             tneg;
    logic             zero;
    logic [2:0][63:0] cmag;
    logic [2:0]       cneg;
    logic [2:0][63:0] lo;
    logic [2:0][64:0] hi;
    logic [63:0]      m;
    logic [2:0][96:0] n;
    logic [3:0]       cnz;
    logic [3:0][3:0]  cpos;
    logic             czero;
    logic [5:0]       e;
    logic [2:0][29:0] cmn;
    logic [2:0][59:0] cmsq;
    logic [61:0]      l2;
  } fs_t;

  fs_t s1, s2, s3, s4, s5, s6, s7, s8, s9, s10;
  fs_t s1_next, s2_next, s3_next, s4_next, s5_next;
  fs_t s6_next, s7_next, s8_next, s9_next, s10_next;
  logic [tbik_pkg::FRONT_LAT-1:0] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[tbik_pkg::FRONT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s1  <= s1_next;
    s2  <= s2_next;
    s3  <= s3_next;
    s4  <= s4_next;
    s5  <= s5_next;
    s6  <= s6_next;
    s7  <= s7_next;
    s8  <= s8_next;
    s9  <= s9_next;
    s10 <= s10_next;
  end

  // Capture the item
  always_comb begin
    s1_next      = '0;
    s1_next.p[0] = item.target_x;
    s1_next.p[1] = item.target_y;
    s1_next.p[2] = item.target_z;
    s1_next.d[0] = item.bend_x;
    s1_next.d[1] = item.bend_y;
    s1_next.d[2] = item.bend_z;
    s1_next.r1   = item.upper_length;
    s1_next.r2   = item.lower_length;
  end

  // Products
  always_comb begin
    s2_next = s1;
    for (int i = 0; i < 3; i++) begin
      s2_next.psq[i]  = tbik_pkg::smul32(s1.p[i], s1.p[i]);
      s2_next.pmag[i] = s1.p[i][31] ? 32'(-s1.p[i]) : s1.p[i];
      s2_next.pneg[i] = s1.p[i][31];
    end
    s2_next.r1s   = 62'(s1.r1) * 62'(s1.r1);
    s2_next.r2s   = 62'(s1.r2) * 62'(s1.r2);
    s2_next.pd[0] = tbik_pkg::smul32(s1.p[1], s1.d[2]);
    s2_next.pd[1] = tbik_pkg::smul32(s1.p[2], s1.d[1]);
    s2_next.pd[2] = tbik_pkg::smul32(s1.p[2], s1.d[0]);
    s2_next.pd[3] = tbik_pkg::smul32(s1.p[0], s1.d[2]);
    s2_next.pd[4] = tbik_pkg::smul32(s1.p[0], s1.d[1]);
    s2_next.pd[5] = tbik_pkg::smul32(s1.p[1], s1.d[0]);
  end

  // Sums and differences
  always_comb begin
    s3_next      = s2;
    s3_next.pp   = s2.psq[0] + s2.psq[1] + s2.psq[2];
    s3_next.dsig = {1'b0, s2.r1s} - {1'b0, s2.r2s};
    for (int i = 0; i < 3; i++) begin
      s3_next.c[i] = {s2.pd[2*i][63], s2.pd[2*i]} - {s2.pd[2*i+1][63], s2.pd[2*i+1]};
    end
  end

  // Center scale numerator t = |p|^2 + r1^2 - r2^2 as sign and magnitude
  always_comb begin
    logic [61:0] dmag;
    s4_next = s3;
    dmag    = 62'(-s3.dsig);
    if (!s3.dsig[62]) begin
      s4_next.t    = {1'b0, s3.pp} + 65'(s3.dsig[61:0]);
      s4_next.tneg = 1'b0;
    end else if (s3.pp >= 64'(dmag)) begin
      s4_next.t    = 65'(s3.pp - 64'(dmag));
      s4_next.tneg = 1'b0;
    end else begin
      s4_next.t    = 65'(64'(dmag) - s3.pp);
      s4_next.tneg = 1'b1;
    end
    s4_next.zero = (s3.pp == 64'd0);
    for (int i = 0; i < 3; i++) begin
      s4_next.cmag[i] = s3.c[i][64] ? 64'(-s3.c[i]) : s3.c[i][63:0];
      s4_next.cneg[i] = s3.c[i][64];
    end
  end

  // Split |p_i| * t into two partial products; largest cross magnitude
  always_comb begin
    logic [63:0] mab;
    s5_next = s4;
    for (int i = 0; i < 3; i++) begin
      s5_next.lo[i] = 64'(s4.pmag[i]) * 64'(s4.t[31:0]);
      s5_next.hi[i] = 65'(s4.pmag[i]) * 65'(s4.t[64:32]);
    end
    mab       = (s4.cmag[0] > s4.cmag[1]) ? s4.cmag[0] : s4.cmag[1];
    s5_next.m = (s4.cmag[2] > mab) ? s4.cmag[2] : mab;
  end

  // Combine partial products; find the top bit inside each 16-bit chunk
  always_comb begin
    s6_next = s5;
    for (int i = 0; i < 3; i++) begin
      s6_next.n[i] = 97'(s5.lo[i]) + {s5.hi[i], 32'd0};
    end
    for (int j = 0; j < 4; j++) begin
      s6_next.cnz[j]  = |s5.m[16*j +: 16];
      s6_next.cpos[j] = '0;
      for (int b = 0; b < 16; b++) begin
        if (s5.m[16*j + b]) s6_next.cpos[j] = 4'(b);
      end
    end
  end

  // Top bit of the whole word
  always_comb begin
    s7_next   = s6;
    s7_next.e = '0;
    for (int j = 0; j < 4; j++) begin
      if (s6.cnz[j]) s7_next.e = {2'(j), s6.cpos[j]};
    end
    s7_next.czero = ~|s6.cnz;
  end

  // Bring the largest magnitude to [2^29, 2^30)
  always_comb begin
    s8_next = s7;
    for (int i = 0; i < 3; i++) begin
      if (s7.e >= 6'd29) begin
        s8_next.cmn[i] = 30'(s7.cmag[i] >> (s7.e - 6'd29));
      end else begin
        s8_next.cmn[i] = 30'(s7.cmag[i] << (6'd29 - s7.e));
      end
    end
  end

  always_comb begin
    s9_next = s8;
    for (int i = 0; i < 3; i++) begin
      s9_next.cmsq[i] = 60'(s8.cmn[i]) * 60'(s8.cmn[i]);
    end
  end

  always_comb begin
    s10_next    = s9;
    s10_next.l2 = 62'(s9.cmsq[0]) + 62'(s9.cmsq[1]) + 62'(s9.cmsq[2]);
  end

  assign out_valid = v[tbik_pkg::FRONT_LAT-1];
  assign num       = s10.n;
  assign den       = s10.pp;

  always_comb begin
    tag       = '0;
    tag.zero  = s10.zero;
    tag.qneg  = s10.pneg ^ {3{s10.tneg}};
    tag.r1s   = s10.r1s;
    tag.cmn   = s10.cmn;
    tag.cneg  = s10.cneg;
    tag.czero = s10.czero;
    tag.l2    = s10.l2;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tbik_qdiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbik_qdiv: pipelined restoring divider for the circle center
// Three lanes share one divisor; one quotient bit per stage, with an early
// flag for quotients of 2^34 and above.
// ----------------------------------------------------------------------------
module tbik_qdiv (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [2:0][96:0]                      num,
  input  logic [63:0]                           den,
  input  tbik_pkg::bundle_t                     in_tag,
  output logic                                  out_valid,
  output logic [2:0][tbik_pkg::QDIV_BITS-1:0]   quo,
  output logic [2:0]                            ovf,
  output tbik_pkg::bundle_t                     out_tag
);

  localparam int L = tbik_pkg::QDIV_LAT;
  localparam int B = tbik_pkg::QDIV_BITS;

  logic [L-1:0]                 v;
  logic [L-1:0][2:0][97:0]      rem;
  logic [L-1:0][2:0][B-1:0]     qs;
  logic [L-1:0][2:0]            ov;
  logic [L-1:0][63:0]           dv;
  tbik_pkg::bundle_t            tg [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[L-2:0], in_valid};
    end
  end

  // Overflow check and load
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rem[0][i] <= 98'(num[i]);
      ov[0][i]  <= 98'(num[i]) >= {den, 34'd0};
      qs[0][i]  <= '0;
    end
    dv[0] <= den;
    tg[0] <= in_tag;
  end

  for (genvar k = 1; k < L; k++) begin : g_step
    localparam int SH = B - k;
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (rem[k-1][i] >= (98'(dv[k-1]) << SH)) begin
          rem[k][i] <= rem[k-1][i] - (98'(dv[k-1]) << SH);
          qs[k][i]  <= qs[k-1][i] | (B'(1) << SH);
        end else begin
          rem[k][i] <= rem[k-1][i];
          qs[k][i]  <= qs[k-1][i];
        end
      end
      ov[k] <= ov[k-1];
      dv[k] <= dv[k-1];
      tg[k] <= tg[k-1];
    end
  end

  assign out_valid = v[L-1];
  assign quo       = qs[L-1];
  assign ovf       = ov[L-1];
  assign out_tag   = tg[L-1];

endmodule
`default_nettype wire

// ===== hw/rtl/tbik_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbik_isqrt: pipelined integer square root, two lanes
// Floor root of a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module tbik_isqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0][63:0]  rad,
  input  tbik_pkg::bundle_t in_tag,
  output logic              out_valid,
  output logic [1:0][31:0]  root,
  output tbik_pkg::bundle_t out_tag
);

  localparam int L = tbik_pkg::ISQRT_LAT;

  logic [L-1:0]            v;
  logic [L-1:0][1:0][63:0] rv;
  logic [L-1:0][1:0][63:0] rr;
  tbik_pkg::bundle_t       tg [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[L-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < L; k++) begin : g_step
    localparam logic [63:0] BIT = 64'(1) << (62 - 2*k);
    logic [1:0][63:0] pv;
    logic [1:0][63:0] pr;
    tbik_pkg::bundle_t ptg;
    if (k == 0) begin : g_first
      assign pv  = rad;
      assign pr  = '0;
      assign ptg = in_tag;
    end else begin : g_rest
      assign pv  = rv[k-1];
      assign pr  = rr[k-1];
      assign ptg = tg[k-1];
    end
    always_ff @(posedge clk) begin
      for (int i = 0; i < 2; i++) begin
        if (pv[i] >= pr[i] + BIT) begin
          rv[k][i] <= pv[i] - (pr[i] + BIT);
          rr[k][i] <= (pr[i] >> 1) + BIT;
        end else begin
          rv[k][i] <= pv[i];
          rr[k][i] <= pr[i] >> 1;
        end
      end
      tg[k] <= ptg;
    end
  end

  assign out_valid = v[L-1];
  assign root[0]   = rr[L-1][0][31:0];
  assign root[1]   = rr[L-1][1][31:0];
  assign out_tag   = tg[L-1];

endmodule
`default_nettype wire

// ===== hw/rtl/tbik_tdiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbik_tdiv: pipelined rounding divider for the sideways terms
// Adds half the divisor, then three lanes of restoring division, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module tbik_tdiv (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic [2:0][61:0]                     prod,
  input  logic [31:0]                          den,
  input  tbik_pkg::bundle_t                    in_tag,
  output logic                                 out_valid,
  output logic [2:0][tbik_pkg::TDIV_BITS-1:0]  quo,
  output tbik_pkg::bundle_t                    out_tag
);

  localparam int L = tbik_pkg::TDIV_LAT;
  localparam int B = tbik_pkg::TDIV_BITS;

  logic [L-1:0]             v;
  logic [L-1:0][2:0][63:0]  rem;
  logic [L-1:0][2:0][B-1:0] qs;
  logic [L-1:0][31:0]       dv;
  tbik_pkg::bundle_t        tg [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[L-2:0], in_valid};
    end
  end

  // Round to nearest: add half the divisor up front
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rem[0][i] <= 64'(prod[i]) + 64'(den >> 1);
      qs[0][i]  <= '0;
    end
    dv[0] <= den;
    tg[0] <= in_tag;
  end

  for (genvar k = 1; k < L; k++) begin : g_step
    localparam int SH = B - k;
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (rem[k-1][i] >= (64'(dv[k-1]) << SH)) begin
          rem[k][i] <= rem[k-1][i] - (64'(dv[k-1]) << SH);
          qs[k][i]  <= qs[k-1][i] | (B'(1) << SH);
        end else begin
          rem[k][i] <= rem[k-1][i];
          qs[k][i]  <= qs[k-1][i];
        end
      end
      dv[k] <= dv[k-1];
      tg[k] <= tg[k-1];
    end
  end

  assign out_valid = v[L-1];
  assign quo       = qs[L-1];
  assign out_tag   = tg[L-1];

endmodule
`default_nettype wire

// ===== hw/rtl/tbik_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbik_checker: port-level checks for the two-bone IK joint solver
// Fixed latency in both directions, reset flush and the zero-target result.
// ----------------------------------------------------------------------------
module tbik_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input tbik_pkg::in_t  item,
  input logic           done,
  input tbik_pkg::out_t result
);

  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("done high right after reset");

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(tbik_pkg::TOTAL_LAT) done)
    else $error("accepted item produced no result at fixed latency");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, tbik_pkg::TOTAL_LAT))
    else $error("result without a matching accepted item");

  a_zero_target: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.target_x == 32'sd0 && item.target_y == 32'sd0
     && item.target_z == 32'sd0)
    |-> ##(tbik_pkg::TOTAL_LAT)
    (done && result.degenerate && !result.unreachable && !result.saturated
     && result.joint_x == 32'sd0 && result.joint_y == 32'sd0
     && result.joint_z == 32'sd0))
    else $error("zero target did not give a zero degenerate result");

endmodule

bind two_bone_ik_joint_solver_unit tbik_checker u_tbik_checker (.*);
`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the two-bone IK joint solver
// Drives random and directed items through the start/busy handshake with
// random gaps, predicts each joint position in a scoreboard and compares
// every done-marked result field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int IN_W = $bits(tbik_pkg::in_t);

  // Predict the solver result for one item and check results in order
  class joint_scoreboard;
    tbik_pkg::out_t expected_joints[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    static function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    static function longint unsigned root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function longint clip(longint v, inout bit s);
      if (v > 64'sd2147483647) begin
        s = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        s = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    static function tbik_pkg::out_t solve_joint(tbik_pkg::in_t x);
      longint p[3], d[3], q[3], c[3];
      longint unsigned cm[3];
      longint unsigned r1s, r2s, pp, qq, t, s, h, m, l2, len, mg, term;
      logic [127:0] quo;
      bit tneg, qsat, sat, unreach, neg;
      longint v;
      tbik_pkg::out_t o;
      p[0] = longint'(x.target_x);
      p[1] = longint'(x.target_y);
      p[2] = longint'(x.target_z);
      d[0] = longint'(x.bend_x);
      d[1] = longint'(x.bend_y);
      d[2] = longint'(x.bend_z);
      o = '0;
      qsat = 0;
      sat = 0;
      unreach = 0;
      pp = 0;
      for (int i = 0; i < 3; i++) pp += mag(p[i]) * mag(p[i]);
      // zero target: everything zero, flag degenerate
      if (pp == 0) begin
        o.degenerate = 1;
        return o;
      end
      r1s = longint'(x.upper_length) * longint'(x.upper_length);
      r2s = longint'(x.lower_length) * longint'(x.lower_length);
      if (r1s >= r2s) begin
        t = pp + (r1s - r2s);
        tneg = 0;
      end else if (pp >= r2s - r1s) begin
        t = pp - (r2s - r1s);
        tneg = 0;
      end else begin
        t = (r2s - r1s) - pp;
        tneg = 1;
      end
      qq = 0;
      for (int i = 0; i < 3; i++) begin
        neg = (p[i] < 0) != tneg;
        quo = (128'(mag(p[i])) * 128'(t)) / 128'(pp);
        if (quo >= (128'd1 << 34)) mg = 64'd1 << 33;
        else mg = (quo[63:0] + 1) >> 1;
        v = neg ? -longint'(mg) : longint'(mg);
        q[i] = clip(v, qsat);
        qq += mag(q[i]) * mag(q[i]);
      end
      // a clipped center or a negative radicand puts the joint out of reach
      if (qsat || qq > r1s) begin
        unreach = 1;
        s = 0;
      end else begin
        s = r1s - qq;
      end
      h = root(s);
      c[0] = p[1] * d[2] - p[2] * d[1];
      c[1] = p[2] * d[0] - p[0] * d[2];
      c[2] = p[0] * d[1] - p[1] * d[0];
      m = 0;
      for (int i = 0; i < 3; i++) begin
        cm[i] = mag(c[i]);
        if (cm[i] > m) m = cm[i];
      end
      if (m == 0) begin
        o.degenerate = 1;
        o.joint_x = 32'(clip(q[0], sat));
        o.joint_y = 32'(clip(q[1], sat));
        o.joint_z = 32'(clip(q[2], sat));
      end else begin
        // normalize the cross product so its largest part lies in [2^29, 2^30)
        while (m >= (64'd1 << 30)) begin
          m = m >> 1;
          for (int i = 0; i < 3; i++) cm[i] = cm[i] >> 1;
        end
        while (m < (64'd1 << 29)) begin
          m = m << 1;
          for (int i = 0; i < 3; i++) cm[i] = cm[i] << 1;
        end
        l2 = 0;
        for (int i = 0; i < 3; i++) l2 += cm[i] * cm[i];
        len = root(l2);
        for (int i = 0; i < 3; i++) begin
          term = (h * cm[i] + (len >> 1)) / len;
          v = c[i] < 0 ? q[i] - longint'(term) : q[i] + longint'(term);
          q[i] = clip(v, sat);
        end
        o.joint_x = 32'(q[0]);
        o.joint_y = 32'(q[1]);
        o.joint_z = 32'(q[2]);
      end
      o.unreachable = unreach;
      o.saturated = sat || qsat;
      return o;
    endfunction

    function void note_item(tbik_pkg::in_t x);
      expected_joints = {expected_joints, solve_joint(x)};
    endfunction

    function void check_result(tbik_pkg::out_t got);
      tbik_pkg::out_t want;
      if (expected_joints.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = expected_joints.pop_front();
      if (got.joint_x !== want.joint_x)
        $display("%0t: joint_x expected %h actual %h", $time, want.joint_x, got.joint_x);
      if (got.joint_y !== want.joint_y)
        $display("%0t: joint_y expected %h actual %h", $time, want.joint_y, got.joint_y);
      if (got.joint_z !== want.joint_z)
        $display("%0t: joint_z expected %h actual %h", $time, want.joint_z, got.joint_z);
      if (got.unreachable !== want.unreachable)
        $display("%0t: unreachable expected %b actual %b", $time, want.unreachable,
                 got.unreachable);
      if (got.degenerate !== want.degenerate)
        $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                 got.degenerate);
      if (got.saturated !== want.saturated)
        $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                 got.saturated);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  tbik_pkg::in_t  item;
  logic done;
  tbik_pkg::out_t result;

  joint_scoreboard sb = new();
  int idle_cycles = 0;
  bit zero_gap_run = 0;

  two_bone_ik_joint_solver_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Monitor: note accepted items, check results, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(item);
      if (done) sb.check_result(result);
      if ((start && !busy) || done) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Hold the item on the bus until the block takes it; keep start high across
  // back-to-back items
  task automatic send_item(tbik_pkg::in_t x, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= x;
    do @(posedge clk); while (busy);
  endtask

  function automatic int draw_gap();
    if ($urandom_range(0, 99) < 3) zero_gap_run = !zero_gap_run;
    return zero_gap_run ? 0 : $urandom_range(0, 18);
  endfunction

  // Signed value in [-2^(bits-1), 2^(bits-1)), with random bit patterns at full width
  function automatic logic [31:0] rnd_val(int bits);
    logic [31:0] v;
    v = $urandom();
    if (bits >= 32) return v;
    return 32'($signed(v) >>> (32 - bits));
  endfunction

  function automatic tbik_pkg::in_t random_item();
    tbik_pkg::in_t x;
    int kind;
    int sz;
    int k;
    kind = $urandom_range(0, 9);
    sz = $urandom_range(18, 26);
    x.target_x = rnd_val(sz);
    x.target_y = rnd_val(sz);
    x.target_z = rnd_val(sz);
    x.bend_x = rnd_val($urandom_range(8, 32));
    x.bend_y = rnd_val($urandom_range(8, 32));
    x.bend_z = rnd_val($urandom_range(8, 32));
    x.upper_length = 31'($urandom_range(0, 1 << sz));
    x.lower_length = 31'($urandom_range(0, 1 << sz));
    case (kind)
      0: begin
        // noise over the full field range
        x = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom()});
      end
      1: begin
        // bend hint parallel to the target or zero
        k = $urandom_range(0, 3);
        x.bend_x = x.target_x * k;
        x.bend_y = x.target_y * k;
        x.bend_z = x.target_z * k;
      end
      2: begin
        // wide extremes of length
        x.upper_length = 31'($urandom());
        x.lower_length = 31'($urandom());
      end
      default: ;
    endcase
    return x;
  endfunction

  tbik_pkg::in_t d_items[$];
  tbik_pkg::in_t x;

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero target
    x = '0;
    x.upper_length = 31'h0001_0000;
    x.bend_x = 32'h0001_0000;
    d_items = {d_items, x};
    // reachable, ordinary geometry
    x = '0;
    x.target_x = 32'h0001_8000;
    x.upper_length = 31'h0001_0000;
    x.lower_length = 31'h0001_0000;
    x.bend_y = 32'h0001_0000;
    d_items = {d_items, x};
    // zero bend, then bend parallel to the target: sideways term dropped
    x.bend_y = 0;
    d_items = {d_items, x};
    x.bend_x = 32'hFFFE_0000;
    d_items = {d_items, x};
    // target beyond reach
    x = '0;
    x.target_y = 32'h0010_0000;
    x.upper_length = 31'h0001_0000;
    x.lower_length = 31'h0001_0000;
    x.bend_z = 32'h0001_0000;
    d_items = {d_items, x};
    // tiny target, huge upper bone: center saturates
    x = '0;
    x.target_z = 32'h0000_0001;
    x.upper_length = 31'h7FFF_FFFF;
    x.bend_x = 32'h7FFF_FFFF;
    d_items = {d_items, x};
    // lower bone longer than the rest: negative scale factor
    x.upper_length = 0;
    x.lower_length = 31'h7FFF_FFFF;
    d_items = {d_items, x};
    // all fields at extremes
    x = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    d_items = {d_items, x};
    x = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0, 31'h0,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    d_items = {d_items, x};
    x = {32'hFFFF_FFFF, 32'h0, 32'h1, 31'h7FFF_FFFF, 31'h0,
         32'h0, 32'hFFFF_FFFF, 32'h0};
    d_items = {d_items, x};
    // large center along x with a large sideways term along z
    x = {32'h7FFF_0000, 32'h0, 32'h0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
         32'h0, 32'h0001_0000, 32'h0};
    d_items = {d_items, x};
    foreach (d_items[i]) send_item(d_items[i], draw_gap());

    for (int n = 0; n < 450; n++) begin
      // drain the pipeline once midway
      if (n == 200) begin
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_joints.size() != 0) @(posedge clk);
      end
      send_item(random_item(), draw_gap());
    end
    start <= 1'b0;

    while (sb.expected_joints.size() != 0) @(posedge clk);
    repeat (tbik_pkg::TOTAL_LAT + 20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
